// ===== rtl/enp_pkg.sv =====
// enp_pkg: shared constants and types for the ellipse nearest point block
// no dependencies
`default_nettype none
package enp_pkg;
  localparam int unsigned DataW = 24;
  localparam int unsigned WideW = 64;
  localparam logic [WideW-1:0] Cap = 64'h0FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;

  typedef struct packed {
    logic             start;
    logic [1:0]       op;
    logic [WideW-1:0] opa;
    logic [WideW-1:0] opb;
  } enp_req_t;
endpackage
`default_nettype wire

// ===== rtl/enp_if.sv =====
// enp_if: valid/ready channel carrying a pair of 24 bit fields
// depends on nothing
`default_nettype none
interface enp_if;
  logic        valid;
  logic        ready;
  logic [23:0] f0;
  logic [23:0] f1;
  modport source (output valid, f0, f1, input ready);
  modport sink (input valid, f0, f1, output ready);
endinterface
`default_nettype wire

// ===== rtl/enp_cfg_if.sv =====
// enp_cfg_if: configuration write channel, register index and write data
// depends on nothing
`default_nettype none
interface enp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ellipse_nearest_point_newton_top.sv =====
// ellipse_nearest_point_newton_top: nearest point on an ellipse by newton steps
// depends on enp_pkg, enp_if, enp_cfg_if, enp_alu
//
// usage: write semi_axis_a (index 0) and semi_axis_b (index 1) on cfg while
// idle, then send a query point (f0 = point_x, f1 = point_y) on pt. one result
// (f0 = near_x, f1 = near_y) comes out on res for each query point.
// all values are unsigned q10.14.
// the block handles one point at a time; pt.ready is low from the transfer of a
// point until its result has been taken. every arithmetic operation runs on one
// shared multiply/divide unit; a divide with a zero numerator or a divisor that
// is not positive skips the bit loop, and a newton step takes 5 divides and 2
// multiplies. the result is held in an output register until res.ready; a
// stalled receiver only delays the next point.
// reset sets both semi-axes to 16.0 and empties the block; cfg.ready is
// always high.
`default_nettype none
module ellipse_nearest_point_newton_top import enp_pkg::*; #(
  parameter int MAX_ITERATIONS = 16,
  parameter int FRAC_BITS = 14
) (
  input wire logic  clk,
  input wire logic  rst,
  enp_cfg_if.sink   cfg,
  enp_if.sink       pt,
  enp_if.source     res
);
  localparam logic [WideW-1:0] One = WideW'(64'd1 << FRAC_BITS);
  localparam logic [WideW-1:0] Eps = WideW'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam int ItW = $clog2(MAX_ITERATIONS + 1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_A2 = 5'd1,  S_B2 = 5'd2,  S_AX = 5'd3,
                         S_BY = 5'd4,  S_INIT = 5'd5, S_GA = 5'd6,  S_GB = 5'd7,
                         S_GA2 = 5'd8, S_GB2 = 5'd9, S_CHK = 5'd10, S_HA = 5'd11,
                         S_HB = 5'd12, S_STEP = 5'd13, S_UPD = 5'd14, S_MX = 5'd15,
                         S_RX = 5'd16, S_MY = 5'd17, S_RY = 5'd18, S_OUT = 5'd19;

  logic [DataW-1:0] semi_a, semi_b, px, py;
  logic [WideW-1:0] a2, b2, ax, by, ga, gb, ga2, gb2, ha, tmp, rx;
  logic signed [WideW-1:0] t, g;
  logic signed [WideW-1:0] g_cur;
  logic [4:0] state;
  logic [ItW-1:0] iter;
  logic wait_alu;
  enp_req_t req;
  logic alu_done;
  logic [WideW-1:0] alu_res;
  logic signed [WideW-1:0] sa, sb, nt;
  logic [WideW:0] hsum;
  logic [WideW-1:0] h;

  enp_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk(clk), .rst(rst), .req(req), .done(alu_done), .result(alu_res)
  );

  assign cfg.ready = 1'b1;
  assign pt.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);
  assign sa = $signed(a2) + t;
  assign sb = $signed(b2) + t;
  assign hsum = {1'b0, ha} + {1'b0, tmp};
  assign h = (hsum > {1'b0, Cap}) ? Cap : hsum[WideW-1:0];
  assign nt = t + $signed(alu_res);
  assign g_cur = $signed(ga2 + gb2) - $signed(One);

  always_comb begin
    req.start = 1'b0;
    req.op = OP_MUL;
    req.opa = '0;
    req.opb = '0;
    if (!wait_alu) begin
      case (state)
        S_A2:   begin req.start = 1'b1; req.opa = WideW'(semi_a); req.opb = WideW'(semi_a); end
        S_B2:   begin req.start = 1'b1; req.opa = WideW'(semi_b); req.opb = WideW'(semi_b); end
        S_AX:   begin req.start = 1'b1; req.opa = WideW'(semi_a); req.opb = WideW'(px); end
        S_BY:   begin req.start = 1'b1; req.opa = WideW'(semi_b); req.opb = WideW'(py); end
        S_GA:   begin req.start = 1'b1; req.op = OP_DIV; req.opa = ax; req.opb = sa; end
        S_GB:   begin req.start = 1'b1; req.op = OP_DIV; req.opa = by; req.opb = sb; end
        S_GA2:  begin req.start = 1'b1; req.opa = ga; req.opb = ga; end
        S_GB2:  begin req.start = 1'b1; req.opa = gb; req.opb = gb; end
        S_HA:   begin req.start = 1'b1; req.op = OP_DIV; req.opa = ga2; req.opb = sa; end
        S_HB:   begin req.start = 1'b1; req.op = OP_DIV; req.opa = gb2; req.opb = sb; end
        S_STEP: begin req.start = 1'b1; req.op = OP_DIV; req.opa = g; req.opb = h << 1; end
        S_MX:   begin req.start = 1'b1; req.opa = a2; req.opb = WideW'(px); end
        S_RX:   begin req.start = 1'b1; req.op = OP_DIV; req.opa = tmp; req.opb = sa; end
        S_MY:   begin req.start = 1'b1; req.opa = b2; req.opb = WideW'(py); end
        S_RY:   begin req.start = 1'b1; req.op = OP_DIV; req.opa = tmp; req.opb = sb; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      semi_a <= DataW'(262144);
      semi_b <= DataW'(262144);
      state <= S_IDLE;
      wait_alu <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == 2'd0) semi_a <= cfg.data;
        else if (cfg.index == 2'd1) semi_b <= cfg.data;
      end
      if (req.start) wait_alu <= 1'b1;
      case (state)
        S_IDLE: if (pt.valid) begin
          px <= pt.f0;
          py <= pt.f1;
          state <= S_A2;
        end
        S_INIT: begin
          t <= (semi_a <= semi_b) ? $signed(ax) - $signed(a2) : $signed(by) - $signed(b2);
          iter <= '0;
          state <= S_GA;
        end
        S_CHK: begin
          g <= g_cur;
          if (g_cur < $signed(Eps) || iter == ItW'(MAX_ITERATIONS)) state <= S_MX;
          else state <= S_HA;
        end
        S_OUT: if (res.ready) state <= S_IDLE;
        default: if (wait_alu && alu_done) begin
          wait_alu <= 1'b0;
          case (state)
            S_A2:  begin a2 <= alu_res; state <= S_B2; end
            S_B2:  begin b2 <= alu_res; state <= S_AX; end
            S_AX:  begin ax <= alu_res; state <= S_BY; end
            S_BY:  begin by <= alu_res; state <= S_INIT; end
            S_GA:  begin ga <= alu_res; state <= S_GB; end
            S_GB:  begin gb <= alu_res; state <= S_GA2; end
            S_GA2: begin ga2 <= alu_res; state <= S_GB2; end
            S_GB2: begin gb2 <= alu_res; state <= S_CHK; end
            S_HA:  begin ha <= alu_res; state <= S_HB; end
            S_HB:  begin tmp <= alu_res; state <= S_STEP; end
            S_STEP: begin
              t <= (nt > $signed(Cap)) ? $signed(Cap) : nt;
              iter <= iter + 1'b1;
              state <= S_GA;
            end
            S_MX:  begin tmp <= alu_res; state <= S_RX; end
            S_RX:  begin rx <= alu_res; state <= S_MY; end
            S_MY:  begin tmp <= alu_res; state <= S_RY; end
            S_RY:  begin
              res.f0 <= (rx > WideW'(24'hFFFFFF)) ? 24'hFFFFFF : rx[DataW-1:0];
              res.f1 <= (alu_res > WideW'(24'hFFFFFF)) ? 24'hFFFFFF : alu_res[DataW-1:0];
              state <= S_OUT;
            end
            default: state <= S_IDLE;
          endcase
        end
      endcase
    end
  end

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.f0)) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    pt.ready |-> !res.valid) else $error("ready while result pending");
  a_iter: assert property (@(posedge clk) disable iff (rst)
    state == S_GA |-> iter <= ItW'(MAX_ITERATIONS)) else $error("iteration overrun");
endmodule
`default_nettype wire

// ===== rtl/enp_alu.sv =====
// enp_alu: shared multi-cycle fixed point multiply and divide unit
// depends on enp_pkg; mul is one bit a cycle shift-add, div is restoring
`default_nettype none
module enp_alu import enp_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire enp_req_t         req,
  output logic                  done,
  output logic [WideW-1:0]      result
);
  localparam int CntW = $clog2(2*WideW + 1);
  logic [2*WideW-1:0] acc;
  logic [2*WideW-1:0] mcand;
  logic [WideW-1:0]   mplier;
  logic [WideW-1:0]   dvs;
  logic [2*WideW:0]   rem;
  logic [2*WideW-1:0] num;
  logic [2*WideW-1:0] quo;
  logic [CntW-1:0]    cnt;
  logic               busy;
  logic [1:0]         op;
  logic               fixed;
  logic [2*WideW-1:0] prod_sh;
  logic [2*WideW:0]   rem_sh;
  logic [2*WideW-1:0] quo_res;

  assign rem_sh = {rem[2*WideW-1:0], num[2*WideW-1]};
  assign prod_sh = acc >> FRAC_BITS;
  assign quo_res = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op <= req.op;
        cnt <= '0;
        fixed <= 1'b0;
        acc <= '0;
        mcand <= {{WideW{1'b0}}, req.opa};
        mplier <= req.opb;
        dvs <= req.opb;
        rem <= '0;
        quo <= '0;
        num <= {{WideW{1'b0}}, req.opa} << FRAC_BITS;
        if (req.op == OP_DIV && (req.opa == '0 || req.opb == '0 || req.opb[WideW-1])) begin
          fixed <= 1'b1;
          result <= (req.opa == '0) ? '0 : Cap;
        end
      end else if (busy) begin
        if (fixed) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (op == OP_MUL) begin
          if (mplier[0]) acc <= acc + mcand;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(WideW)) begin
            busy <= 1'b0;
            done <= 1'b1;
            result <= (prod_sh > {{WideW{1'b0}}, Cap}) ? Cap : prod_sh[WideW-1:0];
          end
        end else begin
          cnt <= cnt + 1'b1;
          num <= num << 1;
          if (rem_sh >= {{(WideW+1){1'b0}}, dvs}) begin
            rem <= rem_sh - {{(WideW+1){1'b0}}, dvs};
            quo <= {quo[2*WideW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[2*WideW-2:0], 1'b0};
          end
          if (cnt == CntW'(2*WideW)) begin
            busy <= 1'b0;
            done <= 1'b1;
            result <= (quo_res > {{WideW{1'b0}}, Cap}) ? Cap : quo_res[WideW-1:0];
          end
        end
      end
    end
  end

  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy || done) else $error("start while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
endmodule
`default_nettype wire
